>>> src/seeded_row_glitch_shifter_unit_defines.svh
// Assertion macros shared by the checker of the row glitch shifter.
// Depends on nothing; taken in by include.
`ifndef SEEDED_ROW_GLITCH_SHIFTER_UNIT_DEFINES_SVH
`define SEEDED_ROW_GLITCH_SHIFTER_UNIT_DEFINES_SVH

// Implication in the same cycle.
`define SRGS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("row glitch shifter port check failed");

// Implication into the next cycle.
`define SRGS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("row glitch shifter port check failed");

`endif

>>> src/srgs_pkg.sv
// Types, constants and helper functions of the row glitch shifter.
// Used by the draw unit, datapath, controller and top level; depends on nothing.
package srgs_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   // The FNV prime is 2^40 + 0x1b3.
   localparam logic [63:0] FNV_PRIME_LOW = 64'h1b3;
   localparam int FNV_PRIME_SHIFT = 40;
   localparam logic [4:0] CHAN_SHIFT_LIMIT = 5'd16;
   localparam logic [6:0] BAND_ROWS_LIMIT = 7'd64;
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   typedef enum logic [2:0] {
      REG_SEED      = 3'd0,
      REG_BAND_ROWS = 3'd1,
      REG_CHAN_MAX  = 3'd2,
      REG_INTENSITY = 3'd3,
      REG_WIDTH     = 3'd4
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_COL, ST_GCOL, ST_ADDR, ST_RDG, ST_RDR, ST_PUSH,
      ST_DRAW, ST_DWAIT, ST_FIN
   } ctrl_state_type;

   typedef enum logic [2:0] {
      DR_IDLE, DR_MUL2, DR_X1, DR_X2, DR_X3, DR_DIV, DR_DONE
   } draw_state_type;

   typedef enum logic [1:0] {RD_G, RD_R, RD_B} rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       col_en;
      logic       wr_en;
      logic       g_en;
      logic       rb_en;
      rd_sel_type rd_sel;
      logic       grab_ga;
      logic       grab_r;
      logic       push;
      logic       draw_start;
      logic       finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_drain;
      logic held;
      logic row_last;
      logic out_free;
      logic draw_done;
   } ctrl_status_type;

   function automatic logic [63:0] xorshift(input logic [63:0] s);
      logic [63:0] t;
      t = s ^ (s << 13);
      t = t ^ (t >> 7);
      t = t ^ (t << 17);
      return t;
   endfunction

   function automatic logic [63:0] fnv_mul(input logic [63:0] a);
      return (a * FNV_PRIME_LOW) + (a << FNV_PRIME_SHIFT);
   endfunction

endpackage

>>> src/srgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module srgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> src/srgs_draw.sv
// Per-band draw unit: FNV mix, three xorshift draws and three serial modulos.
// Depends on srgs_pkg.
module srgs_draw import srgs_pkg::*; #(
   parameter int CW = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           seed,
   input  logic [31:0]           band,
   input  logic [19:0]           intensity,
   input  logic [CW-1:0]         width,
   input  logic [4:0]            cmax,
   output logic                  done,
   output logic signed [CW+4:0]  shift,
   output logic signed [5:0]     red_off,
   output logic signed [5:0]     blue_off
);
   localparam int MSW = CW + 4;
   localparam int DW = MSW + 2;
   localparam int PW = 20 + CW;

   draw_state_type state_ff, state_in;
   logic [63:0]     h_ff, r2_ff, r3_ff, num_ff;
   logic [MSW-1:0]  ms_ff;
   logic [DW-1:0]   rem_ff, trial, divisor, rem_new;
   logic [MSW-1:0]  centre;
   logic [5:0]      cnt_ff;
   logic [1:0]      sel_ff;
   logic [PW-1:0]   prod;
   logic            last_bit;

   assign prod = PW'(intensity) * PW'(width) + PW'(32768);
   assign divisor = (sel_ff == 2'd0) ? DW'({ms_ff, 1'b1}) : DW'({cmax, 1'b1});
   assign centre = (sel_ff == 2'd0) ? ms_ff : MSW'(cmax);
   assign trial = {rem_ff[DW-2:0], num_ff[63]};
   assign rem_new = (trial >= divisor) ? trial - divisor : trial;
   assign last_bit = (cnt_ff == 6'd63);
   assign done = (state_ff == DR_DONE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DR_IDLE: if (start) state_in = DR_MUL2;
         DR_MUL2: state_in = DR_X1;
         DR_X1:   state_in = DR_X2;
         DR_X2:   state_in = DR_X3;
         DR_X3:   state_in = DR_DIV;
         DR_DIV:  if (last_bit && sel_ff == 2'd2) state_in = DR_DONE;
         DR_DONE: state_in = DR_IDLE;
         default: state_in = DR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         DR_IDLE: begin
            h_ff  <= fnv_mul(FNV_BASIS ^ seed);
            ms_ff <= MSW'(prod >> 16);
         end
         DR_MUL2: h_ff <= fnv_mul(h_ff ^ {32'b0, band});
         DR_X1:   h_ff <= xorshift(h_ff);
         DR_X2:   r2_ff <= xorshift(h_ff);
         DR_X3: begin
            r3_ff  <= xorshift(r2_ff);
            num_ff <= h_ff;
            rem_ff <= '0;
            cnt_ff <= '0;
            sel_ff <= 2'd0;
         end
         DR_DIV: begin
            num_ff <= num_ff << 1;
            rem_ff <= rem_new;
            cnt_ff <= cnt_ff + 6'd1;
            if (last_bit) begin
               rem_ff <= '0;
               sel_ff <= sel_ff + 2'd1;
               unique case (sel_ff)
                  2'd0: begin
                     shift  <= $signed((MSW+1)'(rem_new)) - $signed((MSW+1)'(centre));
                     num_ff <= r2_ff;
                  end
                  2'd1: begin
                     red_off <= $signed(6'(rem_new)) - $signed(6'(centre));
                     num_ff  <= r3_ff;
                  end
                  default: blue_off <= $signed(6'(rem_new)) - $signed(6'(centre));
               endcase
            end
         end
         default: ;
      endcase
   end
endmodule

>>> src/srgs_datapath.sv
// Datapath: item capture, counters, row banks, column gather and output register.
// Depends on srgs_pkg, srgs_ram and srgs_draw.
module srgs_datapath import srgs_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   input  logic [63:0]     seed,
   input  logic [6:0]      band_rows,
   input  logic [4:0]      chan_shift_max,
   input  logic [19:0]     intensity_q16,
   input  logic [12:0]     image_width,
   input  logic [31:0]     req_tdata,
   input  logic [1:0]      req_tuser,
   input  logic            rsp_tready,
   output logic            rsp_tvalid,
   output logic [31:0]     rsp_tdata,
   output logic            rsp_tlast
);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int MSW = CW + 4;
   localparam int SW = MSW + 2;
   localparam int RW = ((CW > 6) ? CW : 6) + 2;

   logic              mode_ff, fof_ff, bank_ff, held_ff, out_valid_ff, row_last;
   logic [31:0]       px_ff, band_ff, rdata, q_a, q_b;
   logic [AW-1:0]     cc_ff, col_ff, g_ff, r_ff, b_ff, cc_use, col, wlast, raddr;
   logic [AW-1:0]     g_col, r_col, b_col;
   logic [5:0]        rib_ff;
   logic [6:0]        rib_next, br_eff;
   logic [CW-1:0]     w_eff;
   logic [4:0]        cmax;
   logic signed [MSW:0] shift_ff, d_shift;
   logic signed [5:0] roff_ff, boff_ff, d_roff, d_boff;
   logic [15:0]       ga_ff;
   logic [7:0]        red_ff;
   logic [31:0]       out_data_ff;
   logic              out_last_ff, draw_done;
   logic signed [SW-1:0] gdiff;
   logic signed [RW-1:0] rsum, bsum, wlim;

   always_comb begin
      if (image_width == 13'd0) begin
         w_eff = CW'(1);
      end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(image_width);
      end
   end

   assign wlast = AW'(w_eff - CW'(1));
   assign cmax = (chan_shift_max > CHAN_SHIFT_LIMIT) ? CHAN_SHIFT_LIMIT : chan_shift_max;
   assign br_eff = (band_rows == 7'd0) ? 7'd1 :
                   ((band_rows > BAND_ROWS_LIMIT) ? BAND_ROWS_LIMIT : band_rows);
   assign rib_next = {1'b0, rib_ff} + 7'd1;

   assign cc_use = (!mode_ff && fof_ff) ? '0 : cc_ff;
   assign col = (CW'(cc_use) < w_eff) ? cc_use : '0;
   assign row_last = (CW'(col_ff) == w_eff - CW'(1));

   assign gdiff = $signed(SW'(col_ff)) - SW'(shift_ff);
   assign g_col = (gdiff < 0) ? '0 : ((gdiff >= $signed(SW'(w_eff))) ? wlast : AW'(gdiff));
   assign wlim = $signed(RW'(w_eff));
   assign rsum = $signed(RW'(g_ff)) + RW'(roff_ff);
   assign bsum = $signed(RW'(g_ff)) + RW'(boff_ff);
   assign r_col = (rsum < 0) ? '0 : ((rsum >= wlim) ? wlast : AW'(rsum));
   assign b_col = (bsum < 0) ? '0 : ((bsum >= wlim) ? wlast : AW'(bsum));

   always_comb begin
      unique case (cmd.rd_sel)
         RD_G:    raddr = g_ff;
         RD_R:    raddr = r_ff;
         RD_B:    raddr = b_ff;
         default: raddr = g_ff;
      endcase
   end

   srgs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_ram_a (
      .clock (clock),
      .we    (cmd.wr_en && !bank_ff),
      .waddr (col_ff),
      .wdata (px_ff),
      .raddr (raddr),
      .rdata (q_a)
   );

   srgs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_ram_b (
      .clock (clock),
      .we    (cmd.wr_en && bank_ff),
      .waddr (col_ff),
      .wdata (px_ff),
      .raddr (raddr),
      .rdata (q_b)
   );

   assign rdata = bank_ff ? q_a : q_b;

   srgs_draw #(.CW(CW)) u_draw (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.draw_start),
      .seed      (seed),
      .band      (band_ff),
      .intensity (intensity_q16),
      .width     (w_eff),
      .cmax      (cmax),
      .done      (draw_done),
      .shift     (d_shift),
      .red_off   (d_roff),
      .blue_off  (d_boff)
   );

   assign status.is_drain  = mode_ff;
   assign status.held      = held_ff;
   assign status.row_last  = row_last;
   assign status.out_free  = !out_valid_ff || rsp_tready;
   assign status.draw_done = draw_done;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_tuser[0];
         fof_ff  <= req_tuser[1];
         px_ff   <= req_tdata;
      end
      if (cmd.col_en) col_ff <= col;
      if (cmd.g_en) g_ff <= g_col;
      if (cmd.rb_en) begin
         r_ff <= r_col;
         b_ff <= b_col;
      end
      if (cmd.grab_ga) ga_ff <= {rdata[31:24], rdata[15:8]};
      if (cmd.grab_r) red_ff <= rdata[7:0];
      if (cmd.push) begin
         out_data_ff <= {ga_ff[15:8], rdata[23:16], ga_ff[7:0], red_ff};
         out_last_ff <= row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff        <= '0;
         rib_ff       <= '0;
         band_ff      <= '0;
         bank_ff      <= 1'b0;
         held_ff      <= 1'b0;
         shift_ff     <= '0;
         roff_ff      <= '0;
         boff_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.col_en && !mode_ff && fof_ff) begin
            rib_ff  <= '0;
            band_ff <= '0;
         end
         if (cmd.finish) begin
            if (!row_last) begin
               cc_ff <= col_ff + AW'(1);
            end else if (mode_ff) begin
               held_ff <= 1'b0;
               cc_ff   <= '0;
            end else begin
               bank_ff <= !bank_ff;
               held_ff <= 1'b1;
               cc_ff   <= '0;
               if (rib_next >= br_eff) begin
                  rib_ff  <= '0;
                  band_ff <= band_ff + 32'd1;
               end else begin
                  rib_ff <= rib_next[5:0];
               end
               if (intensity_q16 == 20'd0) begin
                  shift_ff <= '0;
                  roff_ff  <= '0;
                  boff_ff  <= '0;
               end else begin
                  shift_ff <= d_shift;
                  roff_ff  <= d_roff;
                  boff_ff  <= d_boff;
               end
            end
         end
      end
   end
endmodule

>>> src/srgs_ctrl.sv
// Controller state machine that sequences one request through the datapath.
// Depends on srgs_pkg.
module srgs_ctrl import srgs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);
   ctrl_state_type state_ff, state_in;
   logic           go_draw;

   assign go_draw = status.row_last && !status.is_drain;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_G;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_COL;
            end
         end
         ST_COL: begin
            cmd.col_en = 1'b1;
            state_in   = (status.is_drain && !status.held) ? ST_IDLE : ST_GCOL;
         end
         ST_GCOL: begin
            cmd.wr_en = !status.is_drain;
            cmd.g_en  = 1'b1;
            if (status.held) begin
               state_in = ST_ADDR;
            end else begin
               state_in = go_draw ? ST_DRAW : ST_FIN;
            end
         end
         ST_ADDR: begin
            cmd.rb_en  = 1'b1;
            cmd.rd_sel = RD_G;
            state_in   = ST_RDG;
         end
         ST_RDG: begin
            cmd.grab_ga = 1'b1;
            cmd.rd_sel  = RD_R;
            state_in    = ST_RDR;
         end
         ST_RDR: begin
            cmd.grab_r = 1'b1;
            cmd.rd_sel = RD_B;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            cmd.rd_sel = RD_B;
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = go_draw ? ST_DRAW : ST_FIN;
            end
         end
         ST_DRAW: begin
            cmd.draw_start = 1'b1;
            state_in       = ST_DWAIT;
         end
         ST_DWAIT: if (status.draw_done) state_in = ST_FIN;
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

>>> src/seeded_row_glitch_shifter_unit.sv
// Channel   Direction  Contents
// req       in         tdata: red, green, blue, alpha; tuser: mode, first_of_frame
// rsp       out        tdata: red, green, blue, alpha; tlast: row_end
// csr       in/out     APB registers seed, band_rows, chan_shift_max, intensity, width
// A request that gives a result may wait for the result register. A load that ends a
// row also runs the band draws, three 64-step serial modulos. Reset is synchronous;
// the row stores are not cleared. A stalled result holds its register; the next request
// is taken but waits before its own result until then.
module seeded_row_glitch_shifter_unit import srgs_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // red, green, blue, alpha
   input  logic [1:0]        req_tuser,   // mode, first_of_frame
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // red, green, blue, alpha
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   logic [63:0]     seed_ff;
   logic [6:0]      band_rows_ff;
   logic [4:0]      chan_max_ff;
   logic [19:0]     intensity_ff;
   logic [12:0]     width_ff;
   logic            wr;
   csr_reg_type     idx;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = csr_reg_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= 64'd0;
         band_rows_ff <= 7'd8;
         chan_max_ff  <= 5'd0;
         intensity_ff <= 20'd0;
         width_ff     <= 13'd4096;
      end else if (wr) begin
         unique case (idx)
            REG_SEED:      seed_ff      <= csr_pwdata;
            REG_BAND_ROWS: band_rows_ff <= csr_pwdata[6:0];
            REG_CHAN_MAX:  chan_max_ff  <= csr_pwdata[4:0];
            REG_INTENSITY: intensity_ff <= csr_pwdata[19:0];
            REG_WIDTH:     width_ff     <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SEED:      csr_prdata = seed_ff;
         REG_BAND_ROWS: csr_prdata = 64'(band_rows_ff);
         REG_CHAN_MAX:  csr_prdata = 64'(chan_max_ff);
         REG_INTENSITY: csr_prdata = 64'(intensity_ff);
         REG_WIDTH:     csr_prdata = 64'(width_ff);
         default:       csr_prdata = 64'd0;
      endcase
   end

   srgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srgs_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .seed           (seed_ff),
      .band_rows      (band_rows_ff),
      .chan_shift_max (chan_max_ff),
      .intensity_q16  (intensity_ff),
      .image_width    (width_ff),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast)
   );
endmodule

>>> src/srgs_checker.sv
// Port checker for the row glitch shifter, bound to the top level.
// Depends on the assertion macros header.
`include "seeded_row_glitch_shifter_unit_defines.svh"

module srgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);
   `SRGS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `SRGS_ASSERT_NEXT(a_one_request, clock, reset, req_tvalid && req_tready, !req_tready)
   `SRGS_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_tvalid && req_tready)
endmodule

bind seeded_row_glitch_shifter_unit srgs_checker u_srgs_checker (.*);
